/* rtl/core/dmt_pkg.sv */
// ----------------------------------------------------------------------------
// dmt_pkg
// Shared types and constants of the detection merge table.
// ----------------------------------------------------------------------------
package dmt_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int COORD_W     = 12;
    localparam int VAL_W       = 8;
    localparam int CFG_IDX_W   = 1;

    localparam logic [VAL_W-1:0] VAL_ONE = VAL_W'(1);
    localparam logic [VAL_W-1:0] VAL_TEN = VAL_W'(10);
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
    localparam logic [COORD_W-1:0] DIST_RESET = COORD_W'(16);

    localparam logic [CFG_IDX_W-1:0] CFG_DIST_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_Y = 1'b1;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [VAL_W-1:0]   v;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic capture;
        logic scan_rd;
        logic read_rd;
        logic load_result;
    } dmt_cmd_t;

    typedef struct packed {
        logic is_read;
        logic fill_empty;
        logic scan_last;
        logic out_free;
    } dmt_status_t;

    // value plus increment, clamped to the top of the value range
    function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VAL_W] ? VAL_MAX : s[VAL_W-1:0];
    endfunction

endpackage

/* rtl/core/dmt_ram.sv */
// ----------------------------------------------------------------------------
// dmt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/dmt_ctrl.sv */
// ----------------------------------------------------------------------------
// dmt_ctrl
// Sequencer of the merge table: accept, scan the stored entries or read one entry, finish.
// ----------------------------------------------------------------------------
module dmt_ctrl
    import dmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  dmt_status_t status,
    output dmt_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        in_stall        = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                if (status.is_read)
                begin
                    cmd.read_rd = 1'b1;
                    state_next  = S_DONE;
                end
                else if (status.fill_empty)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the result slot is free
                if (status.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/dmt_datapath.sv */
// ----------------------------------------------------------------------------
// dmt_datapath
// Entry store, proximity compare and update, fill count and result register.
// ----------------------------------------------------------------------------
module dmt_datapath
    import dmt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data,
    input  logic                 action,
    input  logic [COORD_W-1:0]   x_pos,
    input  logic [COORD_W-1:0]   y_pos,
    input  logic [VAL_W-1:0]     digit_value,
    input  logic [IDX_W-1:0]     entry_index,
    input  dmt_cmd_t             cmd,
    output dmt_status_t          status,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 merged,
    output logic                 dropped,
    output logic [CNT_W-1:0]     entry_count,
    output logic                 entry_valid,
    output logic [COORD_W-1:0]   out_x,
    output logic [COORD_W-1:0]   out_y,
    output logic [VAL_W-1:0]     out_value
);

    logic [COORD_W-1:0] dist_x_reg;
    logic [COORD_W-1:0] dist_y_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;

    logic               act_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [VAL_W-1:0]   num_reg;
    logic [IDX_W-1:0]   idx_reg;

    logic [IDX_W-1:0]   scan_reg;
    logic               cmp_valid_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               merged_reg;

    logic               out_valid_reg;
    logic               merged_out_reg;
    logic               dropped_out_reg;
    logic [CNT_W-1:0]   count_out_reg;
    logic               valid_out_reg;
    logic [COORD_W-1:0] x_out_reg;
    logic [COORD_W-1:0] y_out_reg;
    logic [VAL_W-1:0]   v_out_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    entry_t             ram_rdata;

    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic               near;
    logic [VAL_W-1:0]   new_v;
    logic               full;
    logic               do_append;
    logic               read_hit;

    dmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // compare the entry read in the previous cycle
    always_comb
    begin
        dx    = (x_reg > ram_rdata.x) ? (x_reg - ram_rdata.x) : (ram_rdata.x - x_reg);
        dy    = (y_reg > ram_rdata.y) ? (y_reg - ram_rdata.y) : (ram_rdata.y - y_reg);
        near  = cmp_valid_reg && (dx < dist_x_reg) && (dy < dist_y_reg);
        new_v = ram_rdata.v;
        if (num_reg == VAL_ONE && x_reg < ram_rdata.x)
        begin
            new_v = sat_add(ram_rdata.v, VAL_TEN);
        end
        else if (ram_rdata.v == VAL_ONE && x_reg > ram_rdata.x)
        begin
            new_v = sat_add(VAL_TEN, num_reg);
        end
    end

    assign full      = (fill_reg == CNT_W'(MAX_ENTRIES));
    assign do_append = cmd.load_result && (act_reg == ACT_ADD) && !merged_reg && !full;
    assign read_hit  = ({{(CNT_W-IDX_W){1'b0}}, idx_reg} < fill_reg);
    assign fill_next = do_append ? (fill_reg + 1'b1) : fill_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cmp_idx_reg;
        ram_wdata = '{x: ram_rdata.x, y: ram_rdata.y, v: new_v};
        if (near)
        begin
            ram_we = 1'b1;
        end
        else if (do_append)
        begin
            ram_we    = 1'b1;
            ram_waddr = fill_reg[IDX_W-1:0];
            ram_wdata = '{x: x_reg, y: y_reg, v: num_reg};
        end
    end

    assign ram_re    = cmd.scan_rd || cmd.read_rd;
    assign ram_raddr = cmd.read_rd ? idx_reg : scan_reg;

    assign status.is_read    = (act_reg == ACT_READ);
    assign status.fill_empty = (fill_reg == '0);
    assign status.scan_last  = (scan_reg == IDX_W'(fill_reg - 1'b1));
    assign status.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_x_reg    <= DIST_RESET;
            dist_y_reg    <= DIST_RESET;
            fill_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DIST_X: dist_x_reg <= cfg_data;
                    CFG_DIST_Y: dist_y_reg <= cfg_data;
                    default:    ;
                endcase
            end
            fill_reg      <= fill_next;
            cmp_valid_reg <= cmd.scan_rd;
            if (cmd.load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg    <= action;
            x_reg      <= x_pos;
            y_reg      <= y_pos;
            num_reg    <= digit_value;
            idx_reg    <= entry_index;
            scan_reg   <= '0;
            merged_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_rd)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (near)
            begin
                merged_reg <= 1'b1;
            end
        end
        cmp_idx_reg <= scan_reg;
        if (cmd.load_result)
        begin
            merged_out_reg  <= (act_reg == ACT_ADD) && merged_reg;
            dropped_out_reg <= (act_reg == ACT_ADD) && !merged_reg && full;
            count_out_reg   <= fill_next;
            valid_out_reg   <= (act_reg == ACT_READ) && read_hit;
            // drop the entry fields unless a read hit a held entry
            if ((act_reg == ACT_READ) && read_hit)
            begin
                x_out_reg <= ram_rdata.x;
                y_out_reg <= ram_rdata.y;
                v_out_reg <= ram_rdata.v;
            end
            else
            begin
                x_out_reg <= '0;
                y_out_reg <= '0;
                v_out_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign merged      = merged_out_reg;
    assign dropped     = dropped_out_reg;
    assign entry_count = count_out_reg;
    assign entry_valid = valid_out_reg;
    assign out_x       = x_out_reg;
    assign out_y       = y_out_reg;
    assign out_value   = v_out_reg;

endmodule

/* rtl/core/detection_merge_table_core.sv */
// ----------------------------------------------------------------------------
// detection_merge_table_core
// Table of detected digit positions, merged by proximity; reads return one entry.
// ----------------------------------------------------------------------------
//  channel  | signals                                      | dir | beat when
//  ---------+----------------------------------------------+-----+----------------------
//  in       | in_valid in_stall action x_pos y_pos         | in  | in_valid & !in_stall
//           | digit_value entry_index                      |     |
//  out      | out_valid out_stall merged dropped           | out | out_valid & !out_stall
//           | entry_count entry_valid out_x out_y out_value |     |
//  cfg      | cfg_we cfg_index cfg_data                    | in  | cfg_we
//
//  An add beat walks the held entries of the entry store through its single read
//  port, compares each with the new detection and then waits for a free result
//  slot; on an empty table it skips the walk. A read beat fetches one entry. One
//  beat is in work at a time; the result register lets the next beat enter while
//  a result waits on out_stall. Reset clears the fill count and restores both
//  merge distances to 16; no clearing pass runs.
// ----------------------------------------------------------------------------
module detection_merge_table_core
    import dmt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic [COORD_W-1:0]   x_pos,
    input  logic [COORD_W-1:0]   y_pos,
    input  logic [VAL_W-1:0]     digit_value,
    input  logic [IDX_W-1:0]     entry_index,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 merged,
    output logic                 dropped,
    output logic [CNT_W-1:0]     entry_count,
    output logic                 entry_valid,
    output logic [COORD_W-1:0]   out_x,
    output logic [COORD_W-1:0]   out_y,
    output logic [VAL_W-1:0]     out_value
);

    dmt_cmd_t    cmd;
    dmt_status_t status;

    dmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    dmt_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .action      (action),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .digit_value (digit_value),
        .entry_index (entry_index),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .merged      (merged),
        .dropped     (dropped),
        .entry_count (entry_count),
        .entry_valid (entry_valid),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_value   (out_value)
    );

endmodule
